// ===== rtl/cfa_pkg.sv =====
package cfa_pkg;

  // Sequencer states of the allocator.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OP_UPD,
    ST_SW_RD,
    ST_SW_CHK
  } state_e;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_PIN   = 2'd1;
  localparam logic [1:0] CMD_UNPIN = 2'd2;
  localparam logic [1:0] CMD_REF   = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd1;
  localparam logic [1:0] STATUS_BAD      = 2'd2;

  // Fixed field widths.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned STAT_W  = 2;

  // Value of the frame count register after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

endpackage

// ===== rtl/cfa_ram.sv =====
module cfa_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/clock_frame_allocator.sv =====
// Frame allocator for a page cache with clock (second-chance) replacement.
// Commands enter on start/cmd_i/frame_i and are taken at a clock edge where
// start is high and busy is low. Each command gives exactly one result on
// granted_frame_o, from_eviction_o and status_o, valid for the single cycle
// in which done_o is high. The receiver cannot hold results off, and the
// next command may be taken in the cycle that shows the previous result.
// The frame count register is written on cfg_data_i when cfg_valid_i is
// high; cfg_ready_o is always high, and writes belong to idle periods.
// Per-frame reference bits and pin counts live in one single-port-write,
// registered-read RAM, so every frame look-up waits for the registered read.
// A fresh allocate or a rejected frame is settled in the decode state; pin,
// unpin and reference read the entry in decode and write it in the update
// state; an allocate that sweeps reads and then checks each frame in turn,
// and sweeps at most twice the active frame count.
// Reset clears the fill count, the clock hand and the sequencer and sets the
// frame count to 64. The RAM needs no clearing: only frames below the fill
// count are ever read, and each of those was written when handed out.
module clock_frame_allocator #(
  parameter int unsigned FRAMES   = 64,
  parameter int unsigned PIN_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [cfa_pkg::CMD_W-1:0]    cmd_i,
  input  logic [cfa_pkg::FRAME_W-1:0]  frame_i,
  output logic                         done_o,
  output logic [cfa_pkg::FRAME_W-1:0]  granted_frame_o,
  output logic                         from_eviction_o,
  output logic [cfa_pkg::STAT_W-1:0]   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfa_pkg::CFG_W-1:0]    cfg_data_i
);

  import cfa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(FRAMES);
  localparam int unsigned CNT_W   = $clog2(FRAMES + 1);
  localparam int unsigned CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned STEP_W  = CMP_W + 1;
  localparam int unsigned ENTRY_W = PIN_BITS + 1;

  localparam logic [CMP_W-1:0]    FRAMES_C = CMP_W'(FRAMES);
  localparam logic [PIN_BITS-1:0] PIN_MAX  = {PIN_BITS{1'b1}};
  localparam logic [PIN_BITS-1:0] PIN_ONE  = PIN_BITS'(1);

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [IDX_W-1:0]     hand_q, hand_d;
  logic [STEP_W-1:0]    steps_q, steps_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic                 done_q, done_d;
  logic [FRAME_W-1:0]   granted_q, granted_d;
  logic                 evict_q, evict_d;
  logic [STAT_W-1:0]    status_q, status_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

  logic [CMP_W-1:0]     cfg_ext, n_ext, fill_ext, hand_ext, frame_ext, hand_inc;
  logic [STEP_W-1:0]    two_n;
  logic                 accept, is_alloc, fresh, bad_frame, frame_free, last_step;
  logic                 rd_ref;
  logic [PIN_BITS-1:0]  rd_pin;
  logic [IDX_W-1:0]     frame_idx, hand_next;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Active frame count, limited to 1..FRAMES.
  assign cfg_ext  = CMP_W'(cfg_q);
  always_comb begin
    if (cfg_ext == '0) begin
      n_ext = CMP_W'(1);
    end else if (cfg_ext > FRAMES_C) begin
      n_ext = FRAMES_C;
    end else begin
      n_ext = cfg_ext;
    end
  end

  assign two_n      = {n_ext, 1'b0};
  assign fill_ext   = CMP_W'(fill_q);
  assign hand_ext   = CMP_W'(hand_q);
  assign frame_ext  = CMP_W'(frame_q);
  assign frame_idx  = IDX_W'(frame_ext);
  assign hand_inc   = hand_ext + CMP_W'(1);
  assign hand_next  = (hand_inc >= n_ext) ? '0 : IDX_W'(hand_inc);

  assign is_alloc   = (cmd_q == CMD_ALLOC);
  assign fresh      = (fill_ext < n_ext);
  assign bad_frame  = (frame_ext >= n_ext) || (frame_ext >= fill_ext);

  assign rd_ref     = ram_rdata[PIN_BITS];
  assign rd_pin     = ram_rdata[PIN_BITS-1:0];
  assign frame_free = !rd_ref && (rd_pin == '0);
  assign last_step  = ((steps_q + STEP_W'(1)) == two_n);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (is_alloc) begin
          state_d = fresh ? ST_IDLE : ST_SW_RD;
        end else begin
          state_d = bad_frame ? ST_IDLE : ST_OP_UPD;
        end
      end
      ST_OP_UPD: state_d = ST_IDLE;
      ST_SW_RD:  state_d = ST_SW_CHK;
      ST_SW_CHK: begin
        if (frame_free || last_step) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SW_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    fill_d    = fill_q;
    hand_d    = hand_q;
    steps_d   = steps_q;
    cmd_d     = cmd_q;
    frame_d   = frame_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    evict_d   = evict_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = hand_q;
    ram_wdata = {1'b0, PIN_ONE};
    ram_raddr = (state_q == ST_DECODE) ? frame_idx : hand_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i;
          frame_d = frame_i;
        end
      end
      ST_DECODE: begin
        if (is_alloc) begin
          if (fresh) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(fill_ext);
            ram_wdata = {1'b0, PIN_ONE};
            fill_d    = fill_q + CNT_W'(1);
            done_d    = 1'b1;
            granted_d = FRAME_W'(fill_ext);
            evict_d   = 1'b0;
            status_d  = STATUS_OK;
          end else begin
            // A hand left beyond a shrunken frame count restarts at zero.
            if (hand_ext >= n_ext) begin
              hand_d = '0;
            end
            steps_d = '0;
          end
        end else if (bad_frame) begin
          done_d    = 1'b1;
          granted_d = frame_q;
          evict_d   = 1'b0;
          status_d  = STATUS_BAD;
        end
      end
      ST_OP_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = frame_idx;
        ram_wdata = ram_rdata;
        done_d    = 1'b1;
        granted_d = frame_q;
        evict_d   = 1'b0;
        status_d  = STATUS_OK;
        unique case (cmd_q)
          CMD_PIN: begin
            if (rd_pin != PIN_MAX) begin
              ram_wdata = {rd_ref, rd_pin + PIN_ONE};
            end
          end
          CMD_UNPIN: begin
            if (rd_pin == '0) begin
              status_d = STATUS_BAD;
            end else begin
              ram_wdata = {rd_ref, rd_pin - PIN_ONE};
            end
          end
          CMD_REF: ram_wdata = {1'b1, rd_pin};
          default: ram_we = 1'b0;
        endcase
      end
      ST_SW_RD: begin
      end
      ST_SW_CHK: begin
        ram_we    = 1'b1;
        ram_waddr = hand_q;
        hand_d    = hand_next;
        if (frame_free) begin
          ram_wdata = {1'b0, PIN_ONE};
          done_d    = 1'b1;
          granted_d = FRAME_W'(hand_ext);
          evict_d   = 1'b1;
          status_d  = STATUS_OK;
        end else begin
          // Second chance: clear the reference bit and move on.
          ram_wdata = {1'b0, rd_pin};
          steps_d   = steps_q + STEP_W'(1);
          if (last_step) begin
            done_d    = 1'b1;
            granted_d = '0;
            evict_d   = 1'b0;
            status_d  = STATUS_NO_FRAME;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= CFG_RESET;
      fill_q  <= '0;
      hand_q  <= '0;
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      fill_q  <= fill_d;
      hand_q  <= hand_d;
      steps_q <= steps_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    frame_q   <= frame_d;
    granted_q <= granted_d;
    evict_q   <= evict_d;
    status_q  <= status_d;
  end

  cfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o          = done_q;
  assign granted_frame_o = granted_q;
  assign from_eviction_o = evict_q;
  assign status_o        = status_q;

  // A result always closes the command: the sequencer is back in idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // A taken command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command taken but block not busy");

  // A failed allocation reports frame zero and no eviction.
  a_fail_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == STATUS_NO_FRAME)) |-> ((granted_q == '0) && !evict_q))
    else $error("failed allocation with nonzero frame or eviction");

  // The fill count never passes the number of frames.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CMP_W'(fill_q) <= FRAMES_C))
    else $error("fill count beyond frame count");

  // While sweeping, the hand stays inside the active frames.
  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SW_CHK) |-> (hand_ext < n_ext))
    else $error("clock hand outside active frames");

endmodule
